@@ rtl/core/tftpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tftpc_pkg
// Types and constants shared by the TFTP client transfer engine.
// ----------------------------------------------------------------------------
package tftpc_pkg;

	// Full data block size; a shorter block ends the transfer
	localparam int BLOCK_BYTES = 512;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_DIRECTION   = 2'd0;
	localparam logic [1:0] REG_SERVER_PORT = 2'd1;
	localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

	localparam logic [15:0] RESET_SERVER_PORT = 16'd69;
	localparam logic [3:0]  RESET_RETRY_LIMIT = 4'd5;

	// request op codes
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_PACKET  = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// transmit opcodes
	localparam logic [2:0] TX_NONE = 3'd0;
	localparam logic [2:0] TX_RRQ  = 3'd1;
	localparam logic [2:0] TX_WRQ  = 3'd2;
	localparam logic [2:0] TX_DATA = 3'd3;
	localparam logic [2:0] TX_ACK  = 3'd4;

	// receive opcodes
	localparam logic [15:0] RX_DATA  = 16'd3;
	localparam logic [15:0] RX_ACK   = 16'd4;
	localparam logic [15:0] RX_ERROR = 16'd5;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BUSY = 2'd1,
		PH_DONE = 2'd2,
		PH_FAIL = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_EMIT,
		ACT_RESEND
	} act_t;

	typedef struct packed {
		logic        direction;
		logic [15:0] server_port;
		logic [3:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] rx_opcode;
		logic [15:0] rx_block;
		logic [15:0] rx_source_port;
		logic [9:0]  rx_payload_len;
		logic [9:0]  next_chunk_len;
	} item_t;

	typedef struct packed {
		logic        send;
		logic [2:0]  tx_opcode;
		logic [15:0] tx_block;
		logic [9:0]  tx_payload_len;
		logic [15:0] dest_port;
		logic        deliver;
		logic [1:0]  status;
	} result_t;

endpackage

@@ rtl/core/tftpc_regs.sv @@
// ----------------------------------------------------------------------------
// tftpc_regs
// APB configuration registers: direction, server port, retry limit.
// ----------------------------------------------------------------------------
module tftpc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tftpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tftpc_pkg::DATA_W-1:0]  pwdata,
	output logic [tftpc_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output tftpc_pkg::cfg_t               cfg
);

	tftpc_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [1:0]      reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction   <= 1'b0;
			cfg_q.server_port <= tftpc_pkg::RESET_SERVER_PORT;
			cfg_q.retry_limit <= tftpc_pkg::RESET_RETRY_LIMIT;
		end else if (wr_en) begin
			case (reg_idx)
				tftpc_pkg::REG_DIRECTION:   cfg_q.direction   <= pwdata[0];
				tftpc_pkg::REG_SERVER_PORT: cfg_q.server_port <= pwdata[15:0];
				tftpc_pkg::REG_RETRY_LIMIT: cfg_q.retry_limit <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tftpc_pkg::REG_DIRECTION:   prdata = {31'd0, cfg_q.direction};
			tftpc_pkg::REG_SERVER_PORT: prdata = {16'd0, cfg_q.server_port};
			tftpc_pkg::REG_RETRY_LIMIT: prdata = {28'd0, cfg_q.retry_limit};
			default:                    prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/tftpc_fsm.sv @@
// ----------------------------------------------------------------------------
// tftpc_fsm
// Transfer state and per-request decision: what to send, new phase.
// ----------------------------------------------------------------------------
module tftpc_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  tftpc_pkg::item_t    item,
	input  tftpc_pkg::cfg_t     cfg,
	output tftpc_pkg::result_t  res
);

	tftpc_pkg::phase_t phase_q, phase_d;
	logic [15:0] exp_q, exp_d;
	logic [3:0]  retries_q, retries_d;
	logic [15:0] peer_q, peer_d;
	logic [2:0]  last_opc_q;
	logic [15:0] last_blk_q;
	logic [9:0]  last_len_q;
	logic        final_q, final_d;

	tftpc_pkg::act_t act;
	logic [2:0]  emit_opc;
	logic [15:0] emit_blk;
	logic [9:0]  emit_len;
	logic        deliver;
	logic [16:0] chunk_x;
	logic [16:0] block_x;
	logic [16:0] len_x;

	assign chunk_x = {7'd0, item.next_chunk_len};
	assign block_x = 17'(tftpc_pkg::BLOCK_BYTES);
	assign len_x   = (chunk_x >= block_x) ? block_x : chunk_x;

	// next state
	always_comb begin
		phase_d   = phase_q;
		exp_d     = exp_q;
		retries_d = retries_q;
		peer_d    = peer_q;
		final_d   = final_q;
		act       = tftpc_pkg::ACT_NONE;
		emit_opc  = tftpc_pkg::TX_NONE;
		emit_blk  = '0;
		emit_len  = '0;
		deliver   = 1'b0;
		case (item.op)
			tftpc_pkg::OP_START: begin
				phase_d   = tftpc_pkg::PH_BUSY;
				exp_d     = 16'd1;
				final_d   = 1'b0;
				peer_d    = cfg.server_port;
				retries_d = cfg.retry_limit;
				act       = tftpc_pkg::ACT_EMIT;
				emit_opc  = cfg.direction ? tftpc_pkg::TX_WRQ : tftpc_pkg::TX_RRQ;
			end
			tftpc_pkg::OP_TIMEOUT: begin
				if (phase_q == tftpc_pkg::PH_BUSY) begin
					if (retries_q <= 4'd1) begin
						retries_d = '0;
						phase_d   = tftpc_pkg::PH_FAIL;
					end else begin
						retries_d = retries_q - 4'd1;
						act       = tftpc_pkg::ACT_RESEND;
					end
				end
			end
			tftpc_pkg::OP_PACKET: begin
				if (phase_q == tftpc_pkg::PH_BUSY) begin
					// first reply from the server latches its transfer port
					peer_d = (peer_q == cfg.server_port) ? item.rx_source_port : peer_q;
					if (item.rx_source_port != peer_d) begin
						if (cfg.retry_limit <= 4'd1) begin
							retries_d = '0;
							phase_d   = tftpc_pkg::PH_FAIL;
						end else begin
							retries_d = cfg.retry_limit - 4'd1;
							act       = tftpc_pkg::ACT_RESEND;
						end
					end else if (item.rx_opcode == tftpc_pkg::RX_ERROR) begin
						phase_d = tftpc_pkg::PH_FAIL;
					end else if (!cfg.direction && item.rx_opcode == tftpc_pkg::RX_DATA
							&& item.rx_block == exp_q) begin
						deliver   = 1'b1;
						retries_d = cfg.retry_limit;
						act       = tftpc_pkg::ACT_EMIT;
						emit_opc  = tftpc_pkg::TX_ACK;
						emit_blk  = exp_q;
						exp_d     = exp_q + 16'd1;
						if ({7'd0, item.rx_payload_len} != block_x)
							phase_d = tftpc_pkg::PH_DONE;
					end else if (cfg.direction && item.rx_opcode == tftpc_pkg::RX_ACK
							&& item.rx_block == exp_q - 16'd1) begin
						if (final_q) begin
							phase_d = tftpc_pkg::PH_DONE;
						end else begin
							if (chunk_x < block_x)
								final_d = 1'b1;
							retries_d = cfg.retry_limit;
							act       = tftpc_pkg::ACT_EMIT;
							emit_opc  = tftpc_pkg::TX_DATA;
							emit_blk  = exp_q;
							emit_len  = len_x[9:0];
							exp_d     = exp_q + 16'd1;
						end
					end else begin
						// wrong opcode or block: resend the last packet
						retries_d = cfg.retry_limit;
						act       = tftpc_pkg::ACT_RESEND;
					end
				end
			end
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		res         = '0;
		res.deliver = deliver;
		res.status  = phase_d;
		case (act)
			tftpc_pkg::ACT_EMIT: begin
				res.send           = 1'b1;
				res.tx_opcode      = emit_opc;
				res.tx_block       = emit_blk;
				res.tx_payload_len = emit_len;
				res.dest_port      = peer_d;
			end
			tftpc_pkg::ACT_RESEND: begin
				res.send           = 1'b1;
				res.tx_opcode      = last_opc_q;
				res.tx_block       = last_blk_q;
				res.tx_payload_len = last_len_q;
				res.dest_port      = peer_d;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tftpc_pkg::PH_IDLE;
			exp_q      <= 16'd1;
			retries_q  <= '0;
			peer_q     <= '0;
			final_q    <= 1'b0;
			last_opc_q <= '0;
			last_blk_q <= '0;
			last_len_q <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			exp_q     <= exp_d;
			retries_q <= retries_d;
			peer_q    <= peer_d;
			final_q   <= final_d;
			if (act == tftpc_pkg::ACT_EMIT) begin
				last_opc_q <= emit_opc;
				last_blk_q <= emit_blk;
				last_len_q <= emit_len;
			end
		end
	end

endmodule

@@ rtl/core/tftp_client_transfer_engine.sv @@
// ----------------------------------------------------------------------------
// tftp_client_transfer_engine
// Control core of a TFTP client (get or put) with an APB register port.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one request: a start, a received
// packet header or a receive timeout. Output channel (out_valid/out_stall)
// returns exactly one result per request: the packet to send (if any), the
// deliver flag and the transfer status after the request.
// An accepted request passes through the input register, then the decision
// logic feeding the result register, before out_valid. Throughput is one
// request per cycle while out_stall holds no result; the state update in
// the decision logic sets that figure.
// When out_stall holds a result, the input register still takes one more
// request, and in_stall rises only once that register is full too.
// Reset clears the transfer to idle, restores the register defaults
// (get, server port 69, five sends) and empties both registers. The user
// must write registers only while no request is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module tftp_client_transfer_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tftpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tftpc_pkg::DATA_W-1:0]  pwdata,
	output logic [tftpc_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [15:0]                   rx_opcode,
	input  logic [15:0]                   rx_block,
	input  logic [15:0]                   rx_source_port,
	input  logic [9:0]                    rx_payload_len,
	input  logic [9:0]                    next_chunk_len,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          send,
	output logic [2:0]                    tx_opcode,
	output logic [15:0]                   tx_block,
	output logic [9:0]                    tx_payload_len,
	output logic [15:0]                   dest_port,
	output logic                          deliver,
	output logic [1:0]                    status
);

	tftpc_pkg::cfg_t    cfg;
	tftpc_pkg::item_t   item_s1;
	tftpc_pkg::result_t res;
	tftpc_pkg::result_t res_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv;
	logic               fire;

	tftpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv      = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.op             <= op;
			item_s1.rx_opcode      <= rx_opcode;
			item_s1.rx_block       <= rx_block;
			item_s1.rx_source_port <= rx_source_port;
			item_s1.rx_payload_len <= rx_payload_len;
			item_s1.next_chunk_len <= next_chunk_len;
		end
	end

	tftpc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign send           = res_s2.send;
	assign tx_opcode      = res_s2.tx_opcode;
	assign tx_block       = res_s2.tx_block;
	assign tx_payload_len = res_s2.tx_payload_len;
	assign dest_port      = res_s2.dest_port;
	assign deliver        = res_s2.deliver;
	assign status         = res_s2.status;

endmodule

@@ rtl/core/tftpc_checker.sv @@
// ----------------------------------------------------------------------------
// tftpc_checker
// Port-level checks on the result channel of the transfer engine.
// ----------------------------------------------------------------------------
module tftpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        send,
	input logic [2:0]  tx_opcode,
	input logic [15:0] tx_block,
	input logic [9:0]  tx_payload_len,
	input logic [15:0] dest_port,
	input logic        deliver,
	input logic [1:0]  status
);

	// a held result keeps its send, opcode, block, port and status fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(send) && $stable(tx_opcode)
			&& $stable(tx_block) && $stable(dest_port) && $stable(status))
		else $error("result changed while stalled");

	// nothing sent means an all-zero packet description
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send |-> tx_opcode == tftpc_pkg::TX_NONE && tx_block == 16'd0
			&& tx_payload_len == 10'd0 && dest_port == 16'd0)
		else $error("packet fields set with send low");

	// stored payload is always acknowledged in the same result
	a_deliver_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && deliver |-> send && tx_opcode == tftpc_pkg::TX_ACK
			&& status != tftpc_pkg::PH_IDLE && status != tftpc_pkg::PH_FAIL)
		else $error("deliver without ack");

	// only data packets carry payload
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_payload_len != 10'd0 |-> send && tx_opcode == tftpc_pkg::TX_DATA)
		else $error("payload length on non-data packet");

endmodule

bind tftp_client_transfer_engine tftpc_checker u_tftpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.send           (send),
	.tx_opcode      (tx_opcode),
	.tx_block       (tx_block),
	.tx_payload_len (tx_payload_len),
	.dest_port      (dest_port),
	.deliver        (deliver),
	.status         (status)
);

@@ dv/tftp_client_transfer_engine_test.sv @@
// ----------------------------------------------------------------------------
// tftp_client_transfer_engine_test
// Self-checking bench for the TFTP client transfer engine. A session tracker
// mirrors the client's transfer state and predicts the result of every
// accepted request. Stimulus is a directed walk through the corner cases,
// then randomized get/put transfers with injected noise under changing
// register settings.
// ----------------------------------------------------------------------------
package tftp_session_check_pkg;

	class client_session_tracker;
		// register copies
		logic                  dir;
		logic [15:0]           srv_port;
		logic [3:0]            retry_max;
		// transfer state
		tftpc_pkg::phase_t     xfer_phase;
		logic [15:0]           next_blk;
		logic [3:0]            tries;
		logic [15:0]           peer;
		logic [2:0]            last_opc;
		logic [15:0]           last_blk;
		logic [9:0]            last_len;
		logic                  final_sent;
		tftpc_pkg::result_t    pending[$];
		int                    mismatches;

		function new();
			dir        = 1'b0;
			srv_port   = tftpc_pkg::RESET_SERVER_PORT;
			retry_max  = tftpc_pkg::RESET_RETRY_LIMIT;
			xfer_phase = tftpc_pkg::PH_IDLE;
			next_blk   = 16'd1;
			tries      = '0;
			peer       = '0;
			last_opc   = tftpc_pkg::TX_NONE;
			last_blk   = '0;
			last_len   = '0;
			final_sent = 1'b0;
			mismatches = 0;
		endfunction

		function tftpc_pkg::result_t last_packet();
			tftpc_pkg::result_t r;
			r = '0;
			r.send           = 1'b1;
			r.tx_opcode      = last_opc;
			r.tx_block       = last_blk;
			r.tx_payload_len = last_len;
			r.dest_port      = peer;
			return r;
		endfunction

		function tftpc_pkg::result_t fresh_packet(logic [2:0] opc, logic [15:0] blk,
				logic [9:0] len);
			last_opc = opc;
			last_blk = blk;
			last_len = len;
			return last_packet();
		endfunction

		function void note_request(tftpc_pkg::item_t req);
			tftpc_pkg::result_t r;
			logic [9:0]         len;
			r = '0;
			case (req.op)
				tftpc_pkg::OP_START: begin
					xfer_phase = tftpc_pkg::PH_BUSY;
					next_blk   = 16'd1;
					final_sent = 1'b0;
					peer       = srv_port;
					tries      = retry_max;
					r = fresh_packet(dir ? tftpc_pkg::TX_WRQ : tftpc_pkg::TX_RRQ,
						16'd0, 10'd0);
				end
				tftpc_pkg::OP_TIMEOUT: if (xfer_phase == tftpc_pkg::PH_BUSY) begin
					if (tries <= 4'd1) begin
						tries      = '0;
						xfer_phase = tftpc_pkg::PH_FAIL;
					end else begin
						tries = tries - 4'd1;
						r = last_packet();
					end
				end
				tftpc_pkg::OP_PACKET: if (xfer_phase == tftpc_pkg::PH_BUSY) begin
					// the server answers from a fresh port; take it on first contact
					if (peer == srv_port)
						peer = req.rx_source_port;
					if (req.rx_source_port != peer) begin
						if (retry_max <= 4'd1) begin
							tries      = '0;
							xfer_phase = tftpc_pkg::PH_FAIL;
						end else begin
							tries = retry_max - 4'd1;
							r = last_packet();
						end
					end else if (req.rx_opcode == tftpc_pkg::RX_ERROR) begin
						xfer_phase = tftpc_pkg::PH_FAIL;
					end else if (!dir && req.rx_opcode == tftpc_pkg::RX_DATA &&
							req.rx_block == next_blk) begin
						tries = retry_max;
						r = fresh_packet(tftpc_pkg::TX_ACK, next_blk, 10'd0);
						r.deliver = 1'b1;
						next_blk = next_blk + 16'd1;
						if (req.rx_payload_len != tftpc_pkg::BLOCK_BYTES)
							xfer_phase = tftpc_pkg::PH_DONE;
					end else if (dir && req.rx_opcode == tftpc_pkg::RX_ACK &&
							req.rx_block == next_blk - 16'd1) begin
						if (final_sent) begin
							xfer_phase = tftpc_pkg::PH_DONE;
						end else begin
							if (req.next_chunk_len >= tftpc_pkg::BLOCK_BYTES) begin
								len = 10'(tftpc_pkg::BLOCK_BYTES);
							end else begin
								len = req.next_chunk_len;
								final_sent = 1'b1;
							end
							tries = retry_max;
							r = fresh_packet(tftpc_pkg::TX_DATA, next_blk, len);
							next_blk = next_blk + 16'd1;
						end
					end else begin
						tries = retry_max;
						r = last_packet();
					end
				end
				default: ;
			endcase
			r.status = xfer_phase;
			pending.push_back(r);
		endfunction

		function void check_result(tftpc_pkg::result_t got);
			tftpc_pkg::result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending: send=%0d op=%0d blk=%0d",
						$realtime, got.send, got.tx_opcode, got.tx_block);
				return;
			end
			want = pending.pop_front();
			if (got.send !== want.send || got.tx_opcode !== want.tx_opcode ||
					got.tx_block !== want.tx_block ||
					got.tx_payload_len !== want.tx_payload_len ||
					got.dest_port !== want.dest_port || got.deliver !== want.deliver ||
					got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch", $realtime);
					$display("  expected send=%0d op=%0d blk=%0d len=%0d port=%0d dlv=%0d st=%0d",
						want.send, want.tx_opcode, want.tx_block, want.tx_payload_len,
						want.dest_port, want.deliver, want.status);
					$display("  actual   send=%0d op=%0d blk=%0d len=%0d port=%0d dlv=%0d st=%0d",
						got.send, got.tx_opcode, got.tx_block, got.tx_payload_len,
						got.dest_port, got.deliver, got.status);
				end
			end
		endfunction
	endclass

endpackage

module tftp_client_transfer_engine_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [tftpc_pkg::ADDR_W-1:0]   paddr;
	logic [tftpc_pkg::DATA_W-1:0]   pwdata;
	logic [tftpc_pkg::DATA_W-1:0]   prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_stall;
	logic [1:0]                     op;
	logic [15:0]                    rx_opcode;
	logic [15:0]                    rx_block;
	logic [15:0]                    rx_source_port;
	logic [9:0]                     rx_payload_len;
	logic [9:0]                     next_chunk_len;
	logic                           out_valid;
	logic                           out_stall;
	logic                           send;
	logic [2:0]                     tx_opcode;
	logic [15:0]                    tx_block;
	logic [9:0]                     tx_payload_len;
	logic [15:0]                    dest_port;
	logic                           deliver;
	logic [1:0]                     status;

	tftp_session_check_pkg::client_session_tracker sb;
	logic tx_quiet;
	logic rx_quiet;
	int   requests_sent;

	tftp_client_transfer_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.rx_opcode      (rx_opcode),
		.rx_block       (rx_block),
		.rx_source_port (rx_source_port),
		.rx_payload_len (rx_payload_len),
		.next_chunk_len (next_chunk_len),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send           (send),
		.tx_opcode      (tx_opcode),
		.tx_block       (tx_block),
		.tx_payload_len (tx_payload_len),
		.dest_port      (dest_port),
		.deliver        (deliver),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic tftpc_pkg::item_t packet(logic [15:0] opc, logic [15:0] blk,
			logic [15:0] port, logic [9:0] len, logic [9:0] chunk);
		tftpc_pkg::item_t req;
		req.op             = tftpc_pkg::OP_PACKET;
		req.rx_opcode      = opc;
		req.rx_block       = blk;
		req.rx_source_port = port;
		req.rx_payload_len = len;
		req.next_chunk_len = chunk;
		return req;
	endfunction

	// op with every other field random (ignored by starts and timeouts)
	function automatic tftpc_pkg::item_t control(logic [1:0] code);
		tftpc_pkg::item_t req;
		req = packet(16'($urandom), 16'($urandom), 16'($urandom),
			10'($urandom), 10'($urandom));
		req.op = code;
		return req;
	endfunction

	// well-formed server reply number k of a transfer of nblk blocks
	function automatic tftpc_pkg::item_t server_reply(int k, int nblk, logic [15:0] port);
		int len;
		if (!sb.dir) begin
			len = 512;
			if (k >= nblk) begin
				len = $urandom_range(0, 1022);
				if (len >= tftpc_pkg::BLOCK_BYTES)
					len++;
			end
			return packet(tftpc_pkg::RX_DATA, 16'(k), port, 10'(len), 10'($urandom));
		end
		if (k < nblk)
			len = $urandom_range(tftpc_pkg::BLOCK_BYTES, 1023);
		else if (k == nblk)
			len = $urandom_range(0, tftpc_pkg::BLOCK_BYTES - 1);
		else
			len = $urandom_range(0, 1023);
		return packet(tftpc_pkg::RX_ACK, 16'(k - 1), port, 10'($urandom), 10'(len));
	endfunction

	// caller stands at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input tftpc_pkg::item_t req);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		op             <= req.op;
		rx_opcode      <= req.rx_opcode;
		rx_block       <= req.rx_block;
		rx_source_port <= req.rx_source_port;
		rx_payload_len <= req.rx_payload_len;
		next_chunk_len <= req.next_chunk_len;
		do @(posedge clk); while (in_stall);
		sb.note_request(req);
		requests_sent++;
		@(negedge clk);
	endtask

	// stop sending and let every outstanding request come back
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			tftpc_pkg::REG_DIRECTION:   sb.dir       = value[0];
			tftpc_pkg::REG_SERVER_PORT: sb.srv_port  = value[15:0];
			tftpc_pkg::REG_RETRY_LIMIT: sb.retry_max = value[3:0];
			default: ;
		endcase
	endtask

	task automatic shuffle_config();
		logic [15:0] port;
		case ($urandom_range(0, 3))
			0:       port = 16'h0000;
			1:       port = 16'hFFFF;
			2:       port = tftpc_pkg::RESET_SERVER_PORT;
			default: port = 16'($urandom);
		endcase
		write_reg(tftpc_pkg::REG_DIRECTION, 32'($urandom_range(0, 1)));
		write_reg(tftpc_pkg::REG_SERVER_PORT, {16'd0, port});
		write_reg(tftpc_pkg::REG_RETRY_LIMIT, 32'($urandom_range(0, 15)));
	endtask

	task automatic run_transfer(input int nblk, input int noise_pct);
		logic [15:0]      peer;
		tftpc_pkg::item_t req;
		int               k;
		int               last;
		peer = ($urandom_range(0, 9) == 0) ? sb.srv_port : 16'($urandom);
		send_request(control(tftpc_pkg::OP_START));
		last = sb.dir ? nblk + 1 : nblk;
		for (k = 1; k <= last; k++) begin
			if (k > 1 && $urandom_range(0, 99) < noise_pct) begin
				req = server_reply(k, nblk, peer);
				case ($urandom_range(0, 9))
					0, 1: req = control(tftpc_pkg::OP_TIMEOUT);
					2:    req.rx_source_port = peer ^ 16'($urandom_range(1, 65535));
					3, 4: req.rx_block = req.rx_block + 16'($urandom_range(1, 65535));
					5:    req.rx_opcode = 16'($urandom);
					6: begin
						send_request(packet(tftpc_pkg::RX_ERROR, 16'($urandom), peer,
							10'($urandom), 10'($urandom)));
						return;
					end
					default: req = control($urandom_range(0, 1) ? OP_UNUSED
						: tftpc_pkg::OP_PACKET);
				endcase
				send_request(req);
			end
			send_request(server_reply(k, nblk, peer));
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n)
				continue;
			break;
		end
	end

	// result side: random stall before each result, then take it
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = rx_quiet ? 0 : $urandom_range(0, 11);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result({send, tx_opcode, tx_block, tx_payload_len, dest_port,
				deliver, status});
			@(negedge clk);
		end
	end

	initial begin
		int start_count;
		int burst;
		int i;
		sb             = new();
		tx_quiet       = 1'b0;
		rx_quiet       = 1'b0;
		requests_sent  = 0;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		op             = tftpc_pkg::OP_START;
		rx_opcode      = '0;
		rx_block       = '0;
		rx_source_port = '0;
		rx_payload_len = '0;
		next_chunk_len = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// get with reset defaults: ignored ops, port latch, retransmits, end cases
		send_request(control(tftpc_pkg::OP_TIMEOUT));
		send_request(packet(tftpc_pkg::RX_DATA, 16'd1, 16'd1000, 10'd512, 10'd0));
		send_request(packet(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF)
			| tftpc_pkg::item_t'(0));
		send_request(control(OP_UNUSED));
		send_request(control(tftpc_pkg::OP_START));
		send_request(packet(tftpc_pkg::RX_DATA, 16'd1, 16'hFFFF, 10'd512, 10'h3FF));
		send_request(packet(tftpc_pkg::RX_DATA, 16'd2, 16'h0000, 10'd512, 10'd0));
		send_request(control(tftpc_pkg::OP_TIMEOUT));
		send_request(packet(tftpc_pkg::RX_DATA, 16'hFFFF, 16'hFFFF, 10'd512, 10'd0));
		send_request(packet(16'hFFFF, 16'd2, 16'hFFFF, 10'd512, 10'd0));
		send_request(control(OP_UNUSED));
		send_request(packet(tftpc_pkg::RX_DATA, 16'd2, 16'hFFFF, 10'h3FF, 10'd0));
		send_request(packet(tftpc_pkg::RX_DATA, 16'd3, 16'hFFFF, 10'd0, 10'd0));
		send_request(control(tftpc_pkg::OP_START));
		send_request(packet(tftpc_pkg::RX_ERROR, 16'd1, 16'd2000, 10'd0, 10'd0));
		send_request(control(tftpc_pkg::OP_START));
		for (i = 0; i < 5; i++)
			send_request(control(tftpc_pkg::OP_TIMEOUT));
		send_request(control(tftpc_pkg::OP_START));
		send_request(packet(tftpc_pkg::RX_DATA, 16'd1, tftpc_pkg::RESET_SERVER_PORT,
			10'd512, 10'd0));
		send_request(packet(tftpc_pkg::RX_DATA, 16'd2, tftpc_pkg::RESET_SERVER_PORT,
			10'd0, 10'd0));
		settle();

		// put at the top port with the largest retry count
		write_reg(tftpc_pkg::REG_DIRECTION, 32'd1);
		write_reg(tftpc_pkg::REG_SERVER_PORT, 32'h0000_FFFF);
		write_reg(tftpc_pkg::REG_RETRY_LIMIT, 32'd15);
		send_request(control(tftpc_pkg::OP_START));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd0, 16'h1234, 10'd0, 10'h3FF));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd0, 16'h1234, 10'd0, 10'd512));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd1, 16'h1234, 10'd0, 10'd512));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd2, 16'h1234, 10'd0, 10'd0));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd3, 16'h1234, 10'h3FF, 10'h3FF));
		settle();

		// retry limit one, then zero: any wrong port or timeout ends the transfer
		write_reg(tftpc_pkg::REG_SERVER_PORT, 32'd0);
		write_reg(tftpc_pkg::REG_RETRY_LIMIT, 32'd1);
		send_request(control(tftpc_pkg::OP_START));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd0, 16'd7, 10'd0, 10'd600));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd1, 16'd8, 10'd0, 10'd600));
		send_request(control(tftpc_pkg::OP_START));
		send_request(control(tftpc_pkg::OP_TIMEOUT));
		settle();
		write_reg(tftpc_pkg::REG_RETRY_LIMIT, 32'd0);
		send_request(control(tftpc_pkg::OP_START));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd0, 16'd9, 10'd0, 10'd600));
		send_request(packet(tftpc_pkg::RX_ACK, 16'd1, 16'd10, 10'd0, 10'd600));
		send_request(control(tftpc_pkg::OP_START));
		send_request(control(tftpc_pkg::OP_TIMEOUT));
		settle();

		// random transfers with noise; settings change between transfers
		write_reg(tftpc_pkg::REG_RETRY_LIMIT, 32'd5);
		start_count = requests_sent;
		while (requests_sent - start_count < 410) begin
			if ($urandom_range(0, 4) == 0) begin
				settle();
				shuffle_config();
			end
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(5, 15);
				for (i = 0; i < burst; i++)
					send_request(control(2'($urandom)));
			end else begin
				run_transfer($urandom_range(1, 8), 15);
			end
		end
		settle();

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ tftp_client_transfer_engine.f @@
rtl/core/tftpc_pkg.sv
rtl/core/tftpc_regs.sv
rtl/core/tftpc_fsm.sv
rtl/core/tftp_client_transfer_engine.sv
rtl/core/tftpc_checker.sv
dv/tftp_client_transfer_engine_test.sv
